// ===== hdl/ffa_pkg.sv =====
// Shared constants, types and codes for the first-fit free-list allocator.
// No dependencies; imported by the top level and the testbench.
package ffa_pkg;

    localparam int HEAP_BYTES   = 1024;
    localparam int ALIGN_BYTES  = 8;
    localparam int HEADER_BYTES = 16;
    localparam int HDR_DEPTH    = HEAP_BYTES / ALIGN_BYTES;

    localparam int IDX_W    = $clog2(HDR_DEPTH);
    localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
    localparam int ADDR_W   = $clog2(HEAP_BYTES);
    localparam int BYTES_W  = 11;
    localparam int SIZE_W   = 11;
    localparam int NEED_W   = BYTES_W + 1;
    localparam int SPLIT_W  = NEED_W + 1;
    localparam int STAT_W   = 2;

    localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
    localparam int HDR_SLOTS = HEADER_BYTES / ALIGN_BYTES;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_ZERO    = 2'd1,
        STAT_NOSPACE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_SPLIT,
        ST_LINK,
        ST_CLEAR,
        ST_RESP
    } state_t;

    // free-list link: valid clear means null
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } link_t;

endpackage

// ===== hdl/first_fit_free_list_allocator.sv =====
// First-fit free-list heap allocator, top level.
// Depends on ffa_pkg and two ffa_ram instances (header size store, header link store).
//
// Usage
//   Input channel (s_*): one transaction per command. s_tuser is the command
//   (0 allocate, 1 free); s_tdata carries alloc_bytes and free_address.
//   Result channel (m_*): exactly one transaction per command, in order, with
//   data_address and status in m_tdata.
//   Allocate rounds the request up to the alignment and walks the free list
//   from its head, one header read per cycle out of the header RAMs. The
//   first block that fits is split (tail stays free) or unlinked whole.
//   Free pushes the header onto the head of the list.
// Walk / throughput
//   Free, zero-size request or empty list: straight from accept to the response state.
//   Allocate: a walk over N headers, N = headers visited (1..128), then the split
//   state (when split), link and clear; a walk that finds no fit goes to response.
//   The walk loop runs through the read port of the header RAMs.
//   One command is in flight at a time; a new command is accepted once the
//   previous one has reached the output register.
// Reset
//   aresetn low for one cycle or more: the list holds one free block at
//   index 0 spanning the heap less one header; no clearing pass is needed.
// Stall
//   While m_tready is low the result waits in the output register; a finished
//   command behind it waits in the response state and s_tready stays low.
module first_fit_free_list_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // [10:0] alloc_bytes, [20:11] free_address, [23:21] zero
    input  logic        s_tuser,  // [0] command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // [9:0] data_address, [11:10] status, [15:12] zero
);

    import ffa_pkg::*;

    // ---------------------------------------------------------------- registers
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic                  head_valid_reg, head_valid_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      prev_reg, prev_next;
    logic                  prev_valid_reg, prev_valid_next;
    logic [IDX_W-1:0]      steps_reg, steps_next;
    logic [NEED_W-1:0]     need_reg, need_next;
    logic                  split_reg, split_next;
    logic [IDX_W-1:0]      nb_reg, nb_next;
    logic [SIZE_W-1:0]     remain_reg, remain_next;
    link_t                 link_cur_reg, link_cur_next;
    // entry 0 still holds its reset contents in each store
    logic                  size0_init_reg, size0_init_next;
    logic                  link0_init_reg, link0_init_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    status_t               res_status_reg, res_status_next;
    logic                  m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]     m_addr_reg, m_addr_next;
    status_t               m_status_reg, m_status_next;

    // ---------------------------------------------------------------- RAM ports
    logic                  sz_we;
    logic [IDX_W-1:0]      sz_waddr;
    logic [SIZE_W-1:0]     sz_wdata;
    logic [SIZE_W-1:0]     sz_q;
    logic                  nx_we;
    logic [IDX_W-1:0]      nx_waddr;
    link_t                 nx_wdata;
    logic [$bits(link_t)-1:0] nx_q;

    // ---------------------------------------------------------------- decode
    logic                  in_acc;
    cmd_t                  cmd;
    logic [BYTES_W-1:0]    req_bytes;
    logic [ADDR_W-1:0]     free_addr;
    logic [ADDR_W-1:0]     free_hdr;
    logic [IDX_W-1:0]      free_idx;
    logic [NEED_W-1:0]     need_calc;
    logic [SIZE_W-1:0]     size_rd;
    link_t                 link_rd;
    logic                  fit;
    logic                  fits_split;
    logic                  walk_fail;
    logic                  resp_load;
    link_t                 head_sel;

    assign cmd       = cmd_t'(s_tuser);
    assign req_bytes = s_tdata[BYTES_W-1:0];
    assign free_addr = s_tdata[BYTES_W +: ADDR_W];
    assign in_acc    = s_tvalid && s_tready;

    assign need_calc = ((NEED_W'(req_bytes) + NEED_W'(ALIGN_BYTES - 1)) >> ALIGN_SH)
                       << ALIGN_SH;
    assign free_hdr  = free_addr - ADDR_W'(HEADER_BYTES);
    assign free_idx  = free_hdr[ADDR_W-1:ALIGN_SH];

    // overlay reset contents of entry 0 until it is first written
    assign size_rd = (size0_init_reg && cur_reg == '0) ? RESET_SIZE : sz_q;
    assign link_rd = (link0_init_reg && cur_reg == '0) ? link_t'('0) : link_t'(nx_q);

    assign fit        = NEED_W'(size_rd) >= need_reg;
    assign fits_split = SPLIT_W'(size_rd) >=
                        (SPLIT_W'(need_reg) + SPLIT_W'(HEADER_BYTES + ALIGN_BYTES));
    assign walk_fail  = !fit && (!link_rd.valid || steps_reg == '1);
    assign resp_load  = !m_valid_reg || m_tready;

    // new head or predecessor link when the found block leaves the list
    assign head_sel = split_reg ? link_t'{valid: 1'b1, idx: nb_reg} : link_cur_reg;

    ffa_ram #(.WIDTH(SIZE_W), .DEPTH(HDR_DEPTH)) u_size_ram (
        .aclk  (aclk),
        .we    (sz_we),
        .waddr (sz_waddr),
        .wdata (sz_wdata),
        .raddr (cur_next),
        .rdata (sz_q)
    );

    ffa_ram #(.WIDTH($bits(link_t)), .DEPTH(HDR_DEPTH)) u_link_ram (
        .aclk  (aclk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (cur_next),
        .rdata (nx_q)
    );

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (cmd == CMD_ALLOC && req_bytes != '0 && head_valid_reg) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_WALK: begin
                if (fit) begin
                    state_next = fits_split ? ST_SPLIT : ST_LINK;
                end else if (walk_fail) begin
                    state_next = ST_RESP;
                end
            end
            ST_SPLIT: state_next = ST_LINK;
            ST_LINK:  state_next = ST_CLEAR;
            ST_CLEAR: state_next = ST_RESP;
            ST_RESP: begin
                if (resp_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs / datapath
    always_comb begin
        s_tready        = (state_reg == ST_IDLE);
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        steps_next      = steps_reg;
        need_next       = need_reg;
        split_next      = split_reg;
        nb_next         = nb_reg;
        remain_next     = remain_reg;
        link_cur_next   = link_cur_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        sz_we           = 1'b0;
        sz_waddr        = cur_reg;
        sz_wdata        = need_reg[SIZE_W-1:0];
        nx_we           = 1'b0;
        nx_waddr        = cur_reg;
        nx_wdata        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    res_addr_next   = '0;
                    res_status_next = STAT_OK;
                    if (cmd == CMD_FREE) begin
                        nx_we           = 1'b1;
                        nx_waddr        = free_idx;
                        nx_wdata        = link_t'{valid: head_valid_reg, idx: head_reg};
                        head_next       = free_idx;
                        head_valid_next = 1'b1;
                    end else if (req_bytes == '0) begin
                        res_status_next = STAT_ZERO;
                    end else if (!head_valid_reg) begin
                        res_status_next = STAT_NOSPACE;
                    end else begin
                        need_next       = need_calc;
                        cur_next        = head_reg;
                        prev_valid_next = 1'b0;
                        steps_next      = '0;
                    end
                end
            end
            ST_WALK: begin
                if (fit) begin
                    split_next    = fits_split;
                    nb_next       = cur_reg + IDX_W'(HDR_SLOTS)
                                    + need_reg[ALIGN_SH +: IDX_W];
                    remain_next   = size_rd - need_reg[SIZE_W-1:0] - SIZE_W'(HEADER_BYTES);
                    link_cur_next = link_rd;
                end else if (walk_fail) begin
                    res_addr_next   = '0;
                    res_status_next = STAT_NOSPACE;
                end else begin
                    prev_next       = cur_reg;
                    prev_valid_next = 1'b1;
                    cur_next        = link_rd.idx;
                    steps_next      = steps_reg + 1'b1;
                end
            end
            ST_SPLIT: begin
                // tail of the found block becomes a free block in its place
                sz_we    = 1'b1;
                sz_waddr = nb_reg;
                sz_wdata = remain_reg;
                nx_we    = 1'b1;
                nx_waddr = nb_reg;
                nx_wdata = link_cur_reg;
            end
            ST_LINK: begin
                sz_we    = 1'b1;
                sz_waddr = cur_reg;
                sz_wdata = need_reg[SIZE_W-1:0];
                if (prev_valid_reg) begin
                    nx_we    = 1'b1;
                    nx_waddr = prev_reg;
                    nx_wdata = head_sel;
                end else begin
                    head_next       = head_sel.idx;
                    head_valid_next = head_sel.valid;
                end
            end
            ST_CLEAR: begin
                nx_we           = 1'b1;
                nx_waddr        = cur_reg;
                nx_wdata        = '0;
                res_addr_next   = ADDR_W'({cur_reg, {ALIGN_SH{1'b0}}})
                                  + ADDR_W'(HEADER_BYTES);
                res_status_next = STAT_OK;
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // output register and entry-0 tracking
    always_comb begin
        m_valid_next    = m_valid_reg && !m_tready;
        m_addr_next     = m_addr_reg;
        m_status_next   = m_status_reg;
        if (state_reg == ST_RESP && resp_load) begin
            m_valid_next  = 1'b1;
            m_addr_next   = res_addr_reg;
            m_status_next = res_status_reg;
        end
        size0_init_next = size0_init_reg && !(sz_we && sz_waddr == '0);
        link0_init_next = link0_init_reg && !(nx_we && nx_waddr == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            head_valid_reg <= 1'b1;
            size0_init_reg <= 1'b1;
            link0_init_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            size0_init_reg <= size0_init_next;
            link0_init_reg <= link0_init_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_valid_reg <= prev_valid_next;
        steps_reg      <= steps_next;
        need_reg       <= need_next;
        split_reg      <= split_next;
        nb_reg         <= nb_next;
        remain_reg     <= remain_next;
        link_cur_reg   <= link_cur_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 16'({m_status_reg, m_addr_reg});

    // ---------------------------------------------------------------- assertions
    a_walk_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && !fit && steps_reg == '1) |=> state_reg == ST_RESP)
        else $error("free-list walk exceeded header count");

    a_no_write_in_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP || state_reg == ST_WALK) |-> (!sz_we && !nx_we))
        else $error("header write outside update states");

    a_head_unlink: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LINK && !prev_valid_reg) |=>
            (head_reg == $past(head_sel.idx) && head_valid_reg == $past(head_sel.valid)))
        else $error("head not updated on unlink of first block");

    a_nospace_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != STAT_OK) |-> m_addr_reg == '0)
        else $error("address reported on failed allocate");

endmodule

// ===== hdl/ffa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/sv/first_fit_free_list_allocator_tb.sv =====
// Self-checking testbench for first_fit_free_list_allocator: directed heap cases, random
// alloc/free traffic with bursty idling on both channels, and checks every result.
// Depends on ffa_pkg and the first_fit_free_list_allocator RTL.
module first_fit_free_list_allocator_tb;
    import ffa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;   // idle cycles with no transaction on either side
    localparam int DRAIN_CYCLES   = 200;    // longer than a full 128-header walk
    localparam int RANDOM_CMDS    = 1680;
    localparam int NOISE_CMDS     = 150;
    localparam int PRINT_CAP      = 50;

    // one command as presented on the input channel
    typedef struct {
        cmd_t             cmd;
        logic [BYTES_W-1:0] nbytes;
        logic [ADDR_W-1:0]  free_addr;
    } heap_cmd_t;

    // one result as expected on the output channel
    typedef struct {
        logic [ADDR_W-1:0] addr;
        status_t           st;
    } grant_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // [10:0] alloc_bytes, [20:11] free_address, [23:21] zero
    logic        s_tuser  = 1'b0; // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [9:0] data_address, [11:10] status, [15:12] zero

    first_fit_free_list_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow heap: header sizes, header links, head of the free list.
    logic [SIZE_W-1:0] blk_size [HDR_DEPTH];
    link_t             hdr_link [HDR_DEPTH];
    bit                hdr_written [HDR_DEPTH]; // entries ever written; only these may be reached
    link_t             shadow_head;

    heap_cmd_t         cmd_queue[$];      // commands waiting for the driver
    grant_t            expected_grants[$]; // predicted results, oldest first
    logic [ADDR_W-1:0] live_blocks[$];    // granted data offsets not yet freed
    status_t           last_status;

    int  issued_cmds   = 0;
    int  accepted_cmds = 0;
    int  error_count   = 0;
    int  idle_cycles   = 0;
    int  send_gap      = 0;
    int  take_gap      = 0;
    bit  gaps_on       = 1'b1;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // header store slot for a freed data offset: step back one header, wrap on the heap
    function automatic int header_slot(input logic [ADDR_W-1:0] addr);
        int hdr;
        hdr = (int'(addr) + HEAP_BYTES - HEADER_BYTES) % HEAP_BYTES;
        return (hdr / ALIGN_BYTES) % HDR_DEPTH;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Applies one accepted command to the shadow heap and queues the result it must produce.
    task automatic apply_heap_command(input heap_cmd_t c);
        grant_t g;
        int     need;
        int     cur;
        int     prev;
        int     nb;
        int     steps;
        bit     found;
        bit     prev_ok;
        g.addr = '0;
        g.st   = STAT_OK;
        if (c.cmd == CMD_FREE) begin
            // push on the head, no coalescing, no validity check
            cur = header_slot(c.free_addr);
            hdr_link[cur] = shadow_head;
            shadow_head = '{1'b1, IDX_W'(cur)};
            for (int k = live_blocks.size() - 1; k >= 0; k--)
                if (header_slot(live_blocks[k]) == cur)
                    live_blocks.delete(k);
        end else if (c.nbytes == '0) begin
            g.st = STAT_ZERO;
        end else begin
            need    = ((int'(c.nbytes) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
            found   = 1'b0;
            prev_ok = 1'b0;
            prev    = 0;
            cur     = int'(shadow_head.idx);
            // first fit; a cyclic list gives up after one pass over the store depth
            if (shadow_head.valid) begin
                for (steps = 0; steps < HDR_DEPTH; steps++) begin
                    if (int'(blk_size[cur]) >= need) begin
                        found = 1'b1;
                        break;
                    end
                    if (!hdr_link[cur].valid)
                        break;
                    prev    = cur;
                    prev_ok = 1'b1;
                    cur     = int'(hdr_link[cur].idx);
                end
            end
            if (!found) begin
                g.st = STAT_NOSPACE;
            end else begin
                if (int'(blk_size[cur]) >= need + HEADER_BYTES + ALIGN_BYTES) begin
                    // split: the tail takes the found block's place in the list
                    nb = ((cur * ALIGN_BYTES + HEADER_BYTES + need) / ALIGN_BYTES) % HDR_DEPTH;
                    blk_size[nb]    = SIZE_W'(int'(blk_size[cur]) - need - HEADER_BYTES);
                    hdr_link[nb]    = hdr_link[cur];
                    hdr_written[nb] = 1'b1;
                    if (prev_ok)
                        hdr_link[prev] = '{1'b1, IDX_W'(nb)};
                    else
                        shadow_head = '{1'b1, IDX_W'(nb)};
                end else if (prev_ok) begin
                    hdr_link[prev] = hdr_link[cur];
                end else begin
                    shadow_head = hdr_link[cur];
                end
                blk_size[cur] = SIZE_W'(need);
                hdr_link[cur] = '0;
                g.addr = ADDR_W'(cur * ALIGN_BYTES + HEADER_BYTES);
                live_blocks.push_back(g.addr);
            end
        end
        last_status = g.st;
        expected_grants.push_back(g);
    endtask

    // Queue one command and hold until it has been taken and predicted.
    task automatic issue(input cmd_t cmd, input int nbytes, input int addr);
        heap_cmd_t c;
        c.cmd       = cmd;
        c.nbytes    = BYTES_W'(nbytes);
        c.free_addr = ADDR_W'(addr);
        @(negedge aclk);
        cmd_queue.push_back(c);
        issued_cmds++;
        wait (accepted_cmds == issued_cmds);
    endtask

    // unused field carries random bits so every command field bit toggles
    task automatic issue_alloc(input int nbytes);
        issue(CMD_ALLOC, nbytes, $urandom_range(0, HEAP_BYTES - 1));
    endtask

    task automatic issue_free(input int addr);
        issue(CMD_FREE, $urandom_range(0, 2047), addr);
    endtask

    // free one live block, sometimes through an unaligned offset into its first word
    task automatic free_random_live();
        logic [ADDR_W-1:0] a;
        a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        if ($urandom_range(0, 4) == 0)
            a = a | ADDR_W'($urandom_range(1, ALIGN_BYTES - 1));
        issue_free(a);
    endtask

    function automatic int random_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 64);
        if (r < 90) return $urandom_range(65, 256);
        if (r < 97) return $urandom_range(257, HEAP_BYTES);
        if (r < 98) return 0;
        return $urandom_range(HEAP_BYTES + 1, 2047);
    endfunction

    // Driver: presents queued commands, holds tvalid until taken, random gap bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (cmd_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 99) < 25) begin
                send_gap = $urandom_range(1, 18) - 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tuser  <= cmd_queue[0].cmd;
                s_tdata  <= {3'b000, cmd_queue[0].free_addr, cmd_queue[0].nbytes};
                void'(cmd_queue.pop_front());
            end
        end
    end

    // Result-side backpressure in bursts; always ready once gaps are off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap--;
            m_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 99) < 10) begin
            take_gap = $urandom_range(1, 18) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: checks each result transaction, predicts each command transaction,
    // and ends the run if the bus goes quiet for too long.
    always @(posedge aclk) begin
        grant_t exp_g;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch($sformatf("unexpected result m_tdata=%h", m_tdata));
                end else begin
                    exp_g = expected_grants.pop_front();
                    if (m_tdata[ADDR_W-1:0] !== exp_g.addr)
                        report_mismatch($sformatf("data_address %0d, expected %0d",
                                                  m_tdata[ADDR_W-1:0], exp_g.addr));
                    if (m_tdata[ADDR_W+STAT_W-1:ADDR_W] !== exp_g.st)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tdata[ADDR_W+STAT_W-1:ADDR_W], exp_g.st));
                end
            end
            if (s_tvalid && s_tready) begin
                apply_heap_command('{cmd_t'(s_tuser), s_tdata[BYTES_W-1:0],
                                     s_tdata[BYTES_W+ADDR_W-1:BYTES_W]});
                accepted_cmds++;
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("first_fit_free_list_allocator verification failed");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [ADDR_W-1:0] victim;
        int                slot;
        for (int k = 0; k < HDR_DEPTH; k++) begin
            blk_size[k]    = '0;
            hdr_link[k]    = '0;
            hdr_written[k] = 1'b0;
        end
        blk_size[0]    = RESET_SIZE;
        hdr_written[0] = 1'b1;
        shadow_head    = '{1'b1, IDX_W'(0)};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero size, oversize, exact fit, empty list, walk to the end of
        // the list, split and unlink both at the head and behind a previous block.
        issue_alloc(0);
        issue_alloc(2047);
        issue_alloc(HEAP_BYTES + 1);
        issue_alloc(1023);               // rounds to the whole heap, cannot fit
        issue_alloc(1);                  // split at the head
        issue_alloc(HEAP_BYTES - 2 * HEADER_BYTES - ALIGN_BYTES); // exact fit, list empties
        issue_alloc(8);                  // empty list
        issue_free(HEADER_BYTES + ALIGN_BYTES + HEADER_BYTES);     // big block back
        issue_free(HEADER_BYTES + 5);    // small block, unaligned offset; now at head
        issue_alloc(990);                // walks both, no fit
        issue_alloc(9);                  // split behind the small block
        issue_alloc(952);                // exact fit behind the small block: unlink
        issue_alloc(8);                  // unlink at the head
        issue_alloc(HEAP_BYTES);
        while (live_blocks.size() > 0)
            issue_free(live_blocks[0]);
        issue_alloc(952);
        issue_alloc(16);

        // let everything drain before the random traffic
        wait (expected_grants.size() == 0);
        repeat (20) @(posedge aclk);

        // Well-formed traffic: frees only hit granted blocks. Some stretches run without gaps.
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            gaps_on = ((i / 150) % 4) != 3;
            if (live_blocks.size() == 0 || $urandom_range(0, 99) < 55)
                issue_alloc(random_size());
            else
                free_random_live();
        end

        // Last part, no idling: double free forming a cyclic list, then broken traffic.
        gaps_on = 1'b0;
        issue_alloc(40);
        if (last_status == STAT_OK) begin
            victim = live_blocks[live_blocks.size() - 1];
            issue_free(victim);
            issue_free(victim);
            issue_alloc(HEAP_BYTES);     // loops the cycle until the walk gives up
        end
        for (int i = 0; i < NOISE_CMDS; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: issue_alloc(random_size());
                4, 5: begin
                    if (live_blocks.size() > 0)
                        free_random_live();
                    else
                        issue_alloc(0);
                end
                6: begin
                    if (live_blocks.size() > 0) begin
                        victim = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                        issue_free(victim);
                        issue_free(victim);
                    end
                end
                default: begin
                    // stale or never-granted header, but only one that holds a written entry
                    do slot = $urandom_range(0, HDR_DEPTH - 1); while (!hdr_written[slot]);
                    issue_free((slot * ALIGN_BYTES + HEADER_BYTES
                                + $urandom_range(0, ALIGN_BYTES - 1)) % HEAP_BYTES);
                end
            endcase
        end

        wait (expected_grants.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("first_fit_free_list_allocator verification clean");
        else
            $display("first_fit_free_list_allocator verification failed");
        $finish;
    end

endmodule
